FILE: rtl/sgpd_pkg.sv
// Shared types and constants of the simple glyph point decoder.
// Used by the controller, the datapath and the top level.
`default_nettype none
package sgpd_pkg;

    localparam int COORD_W   = 22;
    localparam int FLAG_W    = 5;
    localparam int END_W     = 6;
    localparam int HDR_WORDS = 5;
    localparam logic [7:0] HDR_LAST_BYTE = 8'd9;

    // stored flag bit positions, and the repeat bit of the raw flag byte
    localparam int FB_ON     = 0;
    localparam int FB_XSHORT = 1;
    localparam int FB_YSHORT = 2;
    localparam int FB_XSAME  = 3;
    localparam int FB_YSAME  = 4;
    localparam int RB_REPEAT = 3;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PT  = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EARLY = 2'd1;
    localparam logic [1:0] ERR_LIMIT = 2'd2;
    localparam logic [1:0] ERR_ORDER = 2'd3;

    typedef enum logic [2:0] {
        PH_HDR, PH_ENDS, PH_INSTR, PH_FLAGS, PH_REPEAT, PH_XPASS, PH_YPASS, PH_DRAIN
    } t_phase;

    typedef enum logic [3:0] {
        ST_ACCEPT, ST_PROC, ST_HDR_OUT, ST_ERR, ST_REP, ST_STARTX, ST_SX_RD,
        ST_SX_CHK, ST_SY_RD, ST_SY_CHK, ST_PT, ST_FINISH
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       hdr_byte;
        logic       ends_byte;
        logic       instr_byte;
        logic       flag_byte;
        logic       rep_load;
        logic       rep_step;
        logic       pass_byte;
        logic       xpass;
        logic       setx_write;
        logic       start_x;
        logic       start_y;
        logic       emit_hdr;
        logic       emit_pt;
        logic       emit_err;
        logic [1:0] err_code;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
        logic hdr_last;
        logic hdr_fin;
        logic hdr_over;
        logic ends_odd;
        logic ends_over;
        logic ends_order;
        logic ends_last;
        logic instr_done;
        logic flag_rep;
        logic flags_full;
        logic rep_go;
        logic pi_done;
        logic pass_done;
        logic x_break;
        logic y_break;
    } t_status;

    function automatic logic signed [COORD_W-1:0] sx16(input logic [15:0] w);
        return {{(COORD_W-16){w[15]}}, w};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/simple_glyph_point_decoder.sv
// Top level of the simple glyph point decoder: controller plus datapath.
// Depends on sgpd_pkg, sgpd_ctrl, sgpd_dpath (and sgpd_ram below it).
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_data_byte, i_last_byte
//   output    out        o_out_valid / i_out_stall  o_kind ... o_last_result
//
// Each byte passes the accept, process and finish states; the 10th header byte
// adds the header output state, an error the error state, and a repeat count
// the repeat state, one flag per step. A byte that completes a point, and each
// point without coordinate bytes after it, passes the read and check states of
// its pass, and in the Y pass the point state; the X pass opens in its start state.
// Reset is synchronous; the stores need no clearing pass. A stalled output
// holds the sequencer in any state that wants to emit a result.
`default_nettype none
module simple_glyph_point_decoder #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_CONTOURS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_kind,
    output logic signed [21:0]      o_coord_x,
    output logic signed [21:0]      o_coord_y,
    output logic signed [15:0]      o_box_x_max,
    output logic signed [15:0]      o_box_y_max,
    output logic                    o_on_curve,
    output logic                    o_contour_end,
    output logic                    o_composite,
    output logic [1:0]              o_error_code,
    output logic                    o_last_result
);
    import sgpd_pkg::*;

    t_cmd    cmd;
    t_status status;

    sgpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sgpd_dpath #(.MAX_POINTS(MAX_POINTS), .MAX_CONTOURS(MAX_CONTOURS)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_coord_x     (o_coord_x),
        .o_coord_y     (o_coord_y),
        .o_box_x_max   (o_box_x_max),
        .o_box_y_max   (o_box_y_max),
        .o_on_curve    (o_on_curve),
        .o_contour_end (o_contour_end),
        .o_composite   (o_composite),
        .o_error_code  (o_error_code),
        .o_last_result (o_last_result)
    );
endmodule
`default_nettype wire

FILE: rtl/sgpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sgpd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/sgpd_dpath.sv
// Datapath: byte latch, counters, header words, point stores, output register.
// Depends on sgpd_pkg and sgpd_ram; driven by sgpd_ctrl commands.
`default_nettype none
module sgpd_dpath #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_CONTOURS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sgpd_pkg::t_cmd       i_cmd,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_last_byte,
    input  wire logic                 i_out_stall,
    output sgpd_pkg::t_status         o_status,
    output logic                      o_out_valid,
    output logic [1:0]                o_kind,
    output logic signed [21:0]        o_coord_x,
    output logic signed [21:0]        o_coord_y,
    output logic signed [15:0]        o_box_x_max,
    output logic signed [15:0]        o_box_y_max,
    output logic                      o_on_curve,
    output logic                      o_contour_end,
    output logic                      o_composite,
    output logic [1:0]                o_error_code,
    output logic                      o_last_result
);
    import sgpd_pkg::*;

    localparam int PA_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CA_W = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;

    logic [7:0]         r_byte;
    logic               r_last;
    logic [7:0]         r_bc, n_bc;
    logic [15:0]        r_partial, n_partial;
    logic [6:0]         r_cc, n_cc;
    logic [6:0]         r_pc, n_pc;
    logic [6:0]         r_pi, n_pi;
    logic [6:0]         r_cursor, n_cursor;
    logic [COORD_W-1:0] r_rs, n_rs;
    logic [FLAG_W-1:0]  r_pending;
    logic [7:0]         r_rep, n_rep;
    logic [END_W-1:0]   r_prev;
    logic [15:0]        r_hdr [HDR_WORDS];

    logic [15:0]        e16;
    logic [6:0]         cidx;
    logic [FLAG_W-1:0]  fbyte;
    logic [FLAG_W-1:0]  flag_q;
    logic [END_W-1:0]   ends_q;
    logic [COORD_W-1:0] x_q;
    logic               sh, sm, ends_ok, flag_we, x_we, ce;

    assign e16   = {r_partial[15:8], r_byte};
    assign cidx  = r_bc[7:1];
    assign fbyte = {r_byte[5:4], r_byte[2:0]};
    assign sh    = i_cmd.xpass ? flag_q[FB_XSHORT] : flag_q[FB_YSHORT];
    assign sm    = i_cmd.xpass ? flag_q[FB_XSAME] : flag_q[FB_YSAME];
    assign ends_ok = r_bc[0] && !o_status.ends_over && !o_status.ends_order;
    assign ce    = (r_cursor < r_cc) && (r_pi == 7'(ends_q));

    always_comb begin
        o_status.last       = r_last;
        o_status.out_free   = !o_out_valid || !i_out_stall;
        o_status.hdr_last   = (r_bc == HDR_LAST_BYTE);
        o_status.hdr_fin    = r_hdr[0][15] || (r_hdr[0] == 16'd0);
        o_status.hdr_over   = (r_hdr[0] > 16'(MAX_CONTOURS));
        o_status.ends_odd   = r_bc[0];
        o_status.ends_over  = (e16 >= 16'(MAX_POINTS));
        o_status.ends_order = (cidx != 7'd0) && (e16 <= 16'(r_prev));
        o_status.ends_last  = (cidx + 7'd1 >= r_cc);
        o_status.flag_rep   = r_byte[RB_REPEAT];
        o_status.flags_full = (r_pi + 7'd1 >= r_pc);
        o_status.rep_go     = (r_rep != 8'd0) && (r_pi < r_pc);
        o_status.pi_done    = (r_pi >= r_pc);
        o_status.pass_done  = sh || (r_bc != 8'd0);
        o_status.x_break    = flag_q[FB_XSHORT] || !flag_q[FB_XSAME];
        o_status.y_break    = flag_q[FB_YSHORT] || !flag_q[FB_YSAME];
        o_status.instr_done = 1'b0;

        n_bc = r_bc; n_partial = r_partial; n_cc = r_cc; n_pc = r_pc;
        n_pi = r_pi; n_cursor = r_cursor; n_rs = r_rs; n_rep = r_rep;

        if (i_cmd.hdr_byte) begin
            if (!r_bc[0]) begin
                n_partial = {r_byte, 8'h00};
            end
            n_bc = r_bc + 8'd1;
        end
        if (i_cmd.emit_hdr) begin
            n_cc = r_hdr[0][6:0];
            n_bc = 8'd0;
        end
        if (i_cmd.ends_byte) begin
            n_bc = r_bc + 8'd1;
            if (!r_bc[0]) begin
                n_partial = {r_byte, 8'h00};
            end else if (ends_ok && o_status.ends_last) begin
                n_pc = 7'(e16[END_W-1:0]) + 7'd1;
                n_bc = 8'd0;
            end
        end
        if (i_cmd.instr_byte) begin
            if (r_bc == 8'd0) begin
                n_partial = {r_byte, 8'h00};
                n_bc = 8'd1;
            end else if (r_bc == 8'd1) begin
                n_partial = e16;
                n_bc = 8'd2;
            end else begin
                n_partial = r_partial - 16'd1;
            end
            o_status.instr_done = (n_bc == 8'd2) && (n_partial == 16'd0);
            if (o_status.instr_done) begin
                n_pi = 7'd0;
                n_bc = 8'd0;
            end
        end
        if (i_cmd.flag_byte || i_cmd.rep_step) begin
            n_pi = r_pi + 7'd1;
        end
        if (i_cmd.rep_load) begin
            n_rep = r_byte;
        end
        if (i_cmd.rep_step) begin
            n_rep = r_rep - 8'd1;
        end
        if (i_cmd.pass_byte) begin
            if (sh) begin
                n_rs = sm ? r_rs + COORD_W'(r_byte) : r_rs - COORD_W'(r_byte);
            end else if (r_bc == 8'd0) begin
                n_partial = {r_byte, 8'h00};
                n_bc = 8'd1;
            end else begin
                n_rs = r_rs + sx16(e16);
                n_bc = 8'd0;
            end
            if (i_cmd.xpass && o_status.pass_done) begin
                n_pi = r_pi + 7'd1;
            end
        end
        if (i_cmd.setx_write) begin
            n_pi = r_pi + 7'd1;
        end
        if (i_cmd.start_x || i_cmd.start_y) begin
            n_pi = 7'd0;
            n_rs = '0;
            n_bc = 8'd0;
            n_cursor = 7'd0;
        end
        if (i_cmd.emit_pt) begin
            n_pi = r_pi + 7'd1;
            if (ce) begin
                n_cursor = r_cursor + 7'd1;
            end
        end
        if (i_cmd.clear) begin
            n_bc = 8'd0; n_pi = 7'd0; n_rs = '0; n_partial = 16'd0;
        end
    end

    assign flag_we = (i_cmd.flag_byte && (r_pi < r_pc)) || i_cmd.rep_step;
    assign x_we    = (i_cmd.pass_byte && i_cmd.xpass && o_status.pass_done)
                     || i_cmd.setx_write;

    sgpd_ram #(.WIDTH(END_W), .DEPTH(MAX_CONTOURS), .ADDR_W(CA_W)) u_ends (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ends_byte && ends_ok),
        .i_waddr (cidx[CA_W-1:0]),
        .i_wdata (e16[END_W-1:0]),
        .i_raddr (r_cursor[CA_W-1:0]),
        .o_rdata (ends_q)
    );

    sgpd_ram #(.WIDTH(FLAG_W), .DEPTH(MAX_POINTS), .ADDR_W(PA_W)) u_flags (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (r_pi[PA_W-1:0]),
        .i_wdata (i_cmd.flag_byte ? fbyte : r_pending),
        .i_raddr (r_pi[PA_W-1:0]),
        .o_rdata (flag_q)
    );

    sgpd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS), .ADDR_W(PA_W)) u_xs (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (r_pi[PA_W-1:0]),
        .i_wdata (n_rs),
        .i_raddr (r_pi[PA_W-1:0]),
        .o_rdata (x_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= 8'd0; r_partial <= 16'd0; r_cc <= 7'd0; r_pc <= 7'd0;
            r_pi <= 7'd0; r_cursor <= 7'd0; r_rs <= '0; r_rep <= 8'd0;
            r_last <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_bc <= n_bc; r_partial <= n_partial; r_cc <= n_cc; r_pc <= n_pc;
            r_pi <= n_pi; r_cursor <= n_cursor; r_rs <= n_rs; r_rep <= n_rep;
            if (i_cmd.accept) begin
                r_last <= i_last_byte;
            end
            if (i_cmd.emit_hdr || i_cmd.emit_pt || i_cmd.emit_err) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.hdr_byte && r_bc[0] && (r_bc[3:1] < 3'(HDR_WORDS))) begin
            r_hdr[r_bc[3:1]] <= e16;
        end
        if (i_cmd.flag_byte && r_byte[RB_REPEAT]) begin
            r_pending <= fbyte;
        end
        if (i_cmd.ends_byte && ends_ok) begin
            r_prev <= e16[END_W-1:0];
        end
        if (i_cmd.emit_hdr) begin
            o_kind        <= KIND_HDR;
            o_coord_x     <= sx16(r_hdr[1]);
            o_coord_y     <= sx16(r_hdr[2]);
            o_box_x_max   <= r_hdr[3];
            o_box_y_max   <= r_hdr[4];
            o_on_curve    <= 1'b0;
            o_contour_end <= 1'b0;
            o_composite   <= r_hdr[0][15];
            o_error_code  <= ERR_NONE;
            o_last_result <= o_status.hdr_fin;
        end else if (i_cmd.emit_pt) begin
            o_kind        <= KIND_PT;
            o_coord_x     <= x_q;
            o_coord_y     <= r_rs;
            o_box_x_max   <= 16'sd0;
            o_box_y_max   <= 16'sd0;
            o_on_curve    <= flag_q[FB_ON];
            o_contour_end <= ce;
            o_composite   <= 1'b0;
            o_error_code  <= ERR_NONE;
            o_last_result <= (r_pi + 7'd1 == r_pc);
        end else if (i_cmd.emit_err) begin
            o_kind        <= KIND_ERR;
            o_coord_x     <= '0;
            o_coord_y     <= '0;
            o_box_x_max   <= 16'sd0;
            o_box_y_max   <= 16'sd0;
            o_on_curve    <= 1'b0;
            o_contour_end <= 1'b0;
            o_composite   <= 1'b0;
            o_error_code  <= i_cmd.err_code;
            o_last_result <= 1'b1;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/sgpd_ctrl.sv
// Controller: record phase and per-byte sequencing state machine.
// Depends on sgpd_pkg; issues commands to sgpd_dpath.
`default_nettype none
module sgpd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sgpd_pkg::t_status i_status,
    output sgpd_pkg::t_cmd         o_cmd
);
    import sgpd_pkg::*;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [1:0] r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
            r_phase <= PH_HDR;
            r_err   <= ERR_NONE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_err   <= n_err;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_err   = r_err;
        o_cmd   = '0;
        o_in_stall = (r_state != ST_ACCEPT);
        case (r_state)
            ST_ACCEPT: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_PROC;
                end
            end
            ST_PROC: begin
                n_state = ST_FINISH;
                case (r_phase)
                    PH_HDR: begin
                        o_cmd.hdr_byte = 1'b1;
                        if (i_status.hdr_last) n_state = ST_HDR_OUT;
                    end
                    PH_ENDS: begin
                        o_cmd.ends_byte = 1'b1;
                        if (i_status.ends_odd) begin
                            if (i_status.ends_over) begin
                                n_err = ERR_LIMIT;
                                n_state = ST_ERR;
                            end else if (i_status.ends_order) begin
                                n_err = ERR_ORDER;
                                n_state = ST_ERR;
                            end else if (i_status.ends_last) begin
                                n_phase = PH_INSTR;
                            end
                        end
                    end
                    PH_INSTR: begin
                        o_cmd.instr_byte = 1'b1;
                        if (i_status.instr_done) n_phase = PH_FLAGS;
                    end
                    PH_FLAGS: begin
                        o_cmd.flag_byte = 1'b1;
                        if (i_status.flag_rep) begin
                            n_phase = PH_REPEAT;
                        end else if (i_status.flags_full) begin
                            n_state = ST_STARTX;
                        end
                    end
                    PH_REPEAT: begin
                        o_cmd.rep_load = 1'b1;
                        n_state = ST_REP;
                    end
                    PH_XPASS, PH_YPASS: begin
                        o_cmd.pass_byte = 1'b1;
                        o_cmd.xpass = (r_phase == PH_XPASS);
                        if (i_status.pass_done) begin
                            n_state = (r_phase == PH_XPASS) ? ST_SX_RD : ST_PT;
                        end
                    end
                    default: begin
                        // drop trailing bytes
                    end
                endcase
            end
            ST_HDR_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_hdr = 1'b1;
                    n_state = ST_FINISH;
                    if (i_status.hdr_fin) begin
                        n_phase = PH_DRAIN;
                    end else if (i_status.hdr_over) begin
                        n_err = ERR_LIMIT;
                        n_state = ST_ERR;
                    end else begin
                        n_phase = PH_ENDS;
                    end
                end
            end
            ST_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = r_err;
                    n_phase = PH_DRAIN;
                    n_state = ST_FINISH;
                end
            end
            ST_REP: begin
                if (i_status.rep_go) begin
                    o_cmd.rep_step = 1'b1;
                end else if (i_status.pi_done) begin
                    n_state = ST_STARTX;
                end else begin
                    n_phase = PH_FLAGS;
                    n_state = ST_FINISH;
                end
            end
            ST_STARTX: begin
                o_cmd.start_x = 1'b1;
                n_phase = PH_XPASS;
                n_state = ST_SX_RD;
            end
            ST_SX_RD: begin
                if (i_status.pi_done) begin
                    o_cmd.start_y = 1'b1;
                    n_phase = PH_YPASS;
                    n_state = ST_SY_RD;
                end else begin
                    n_state = ST_SX_CHK;
                end
            end
            ST_SX_CHK: begin
                // copy the running sum into points that carry no X bytes
                if (i_status.x_break) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.setx_write = 1'b1;
                    n_state = ST_SX_RD;
                end
            end
            ST_SY_RD: begin
                if (i_status.pi_done) begin
                    n_phase = PH_DRAIN;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SY_CHK;
                end
            end
            ST_SY_CHK: begin
                n_state = i_status.y_break ? ST_FINISH : ST_PT;
            end
            ST_PT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_pt = 1'b1;
                    n_state = ST_SY_RD;
                end
            end
            ST_FINISH: begin
                if (!i_status.last) begin
                    n_state = ST_ACCEPT;
                end else if (r_phase == PH_DRAIN) begin
                    o_cmd.clear = 1'b1;
                    n_phase = PH_HDR;
                    n_state = ST_ACCEPT;
                end else if (i_status.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = ERR_EARLY;
                    o_cmd.clear = 1'b1;
                    n_phase = PH_HDR;
                    n_state = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end
endmodule
`default_nettype wire
